>>> rtl/ihpu_pkg.sv
// Shared types and constants for the indexed heap priority update block.
`default_nettype none
package ihpu_pkg;
  localparam int unsigned DEPTH    = 1024;
  localparam int unsigned KEY_BITS = 32;
  localparam int unsigned ENT_BITS = $clog2(DEPTH);
  localparam int unsigned SLOT_BITS = $clog2(DEPTH + 1);

  typedef logic [KEY_BITS-1:0]  key_t;
  typedef logic [ENT_BITS-1:0]  ent_t;
  typedef logic [SLOT_BITS-1:0] slot_t;

  localparam logic OP_SET  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Slot selects for the slot-to-entry read.
  localparam logic [1:0] SEL_PARENT = 2'd0;
  localparam logic [1:0] SEL_LEFT   = 2'd1;
  localparam logic [1:0] SEL_RIGHT  = 2'd2;
  localparam logic [1:0] SEL_ROOT   = 2'd3;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_RD_E, ST_RD_OLD,
    ST_UP_P1, ST_UP_P2, ST_UP_P3,
    ST_DN_C1, ST_DN_C2, ST_DN_C3, ST_DN_C4, ST_DN_C5,
    ST_PLACE, ST_TOP1, ST_TOP2, ST_TOP3, ST_OUT
  } state_e;

  // Commands from controller to datapath.
  typedef struct packed {
    logic clr_step;
    logic latch_req;
    logic rd_req;         // read entry_to_slot and key_store at the request entry
    logic start;          // take slot and old key, store new key on a set
    logic rd_s2e;         // slot_to_entry read at the slot chosen by sel_a
    logic [1:0] sel_a;
    logic rd_key_s2e;     // key_store read at the entry from the s2e read data
    logic latch_ce;       // take s2e read data as candidate entry
    logic latch_ck;       // take key read data as candidate key, left child
    logic pick_right;     // candidate becomes the right child
    logic move_up;        // place candidate at current slot, step to parent
    logic move_dn;        // place candidate at current slot, step to child
    logic place;          // place moving entry at current slot
    logic latch_te;
    logic latch_tk;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_set;
    logic rd_lt_new;      // key read data < new key
    logic at_root;
    logic no_child;
    logic has_right;
    logic right_bigger;   // candidate key < key read data
    logic dn_go;          // new key < candidate key
  } stat_t;
endpackage
`default_nettype wire

>>> rtl/ihpu_datapath.sv
// Datapath: key and map memories, slot walk registers, result registers.
`default_nettype none
module ihpu_datapath import ihpu_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cmd_t  cmd_i,
  input  wire logic  op_i,
  input  wire ent_t  entry_i,
  input  wire key_t  key_i,
  output stat_t      stat_o,
  output key_t       entry_key_o,
  output ent_t       top_entry_o,
  output key_t       top_key_o
);
  key_t key_mem [DEPTH];
  slot_t e2s_mem [DEPTH];
  ent_t s2e_mem [DEPTH];

  slot_t clr_q;
  logic op_q; ent_t ent_q; key_t nk_q;
  slot_t slot_q;
  key_t k_rd_q; slot_t e2s_rd_q; ent_t s2e_rd_q;
  ent_t ce_q; key_t ck_q; logic pick_q;
  key_t ek_q, tk_q; ent_t te_q;

  // Address of the slot-indexed read.
  slot_t addr_a;
  always_comb begin
    case (cmd_i.sel_a)
      SEL_PARENT: addr_a = slot_q >> 1;
      SEL_LEFT: addr_a = slot_t'(slot_q << 1);
      SEL_RIGHT: addr_a = slot_t'((slot_q << 1) | 1'b1);
      SEL_ROOT: addr_a = slot_t'(1);
      default: addr_a = slot_t'(1);
    endcase
  end

  // Clearing pass counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else if (cmd_i.clr_step) clr_q <= slot_t'(clr_q + 1'b1);
  end

  // Memories: one write and one read port each.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      key_mem[clr_q[ENT_BITS-1:0]] <= '0;
      e2s_mem[clr_q[ENT_BITS-1:0]] <= slot_t'(clr_q + 1'b1);
      s2e_mem[clr_q[ENT_BITS-1:0]] <= ent_t'(clr_q);
    end else if (cmd_i.move_up || cmd_i.move_dn) begin
      s2e_mem[ENT_BITS'(slot_q - 1'b1)] <= ce_q;
      e2s_mem[ce_q] <= slot_q;
    end else if (cmd_i.place) begin
      s2e_mem[ENT_BITS'(slot_q - 1'b1)] <= ent_q;
      e2s_mem[ent_q] <= slot_q;
    end
    if (cmd_i.start && op_q == OP_SET) key_mem[ent_q] <= nk_q;
    if (cmd_i.rd_req) k_rd_q <= key_mem[ent_q];
    else if (cmd_i.rd_key_s2e) k_rd_q <= key_mem[s2e_rd_q];
    if (cmd_i.rd_req) e2s_rd_q <= e2s_mem[ent_q];
    if (cmd_i.rd_s2e) s2e_rd_q <= s2e_mem[ENT_BITS'(addr_a - 1'b1)];
  end

  // Request, walk and result registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_req) begin
      op_q <= op_i; ent_q <= entry_i; nk_q <= key_i;
    end
    if (cmd_i.start) begin
      slot_q <= e2s_rd_q;
      ek_q <= (op_q == OP_SET) ? nk_q : k_rd_q;
    end
    if (cmd_i.latch_ce) ce_q <= s2e_rd_q;
    if (cmd_i.latch_ck) begin ck_q <= k_rd_q; pick_q <= 1'b0; end
    if (cmd_i.pick_right) begin ce_q <= s2e_rd_q; ck_q <= k_rd_q; pick_q <= 1'b1; end
    if (cmd_i.move_up) slot_q <= slot_q >> 1;
    if (cmd_i.move_dn) slot_q <= slot_t'({slot_q, pick_q});
    if (cmd_i.latch_te) te_q <= s2e_rd_q;
    if (cmd_i.latch_tk) tk_q <= k_rd_q;
  end

  // Status toward the controller.
  always_comb begin
    stat_o.clr_done     = (clr_q == slot_t'(DEPTH));
    stat_o.is_set       = (op_q == OP_SET);
    stat_o.rd_lt_new    = k_rd_q < nk_q;
    stat_o.at_root      = slot_q == slot_t'(1);
    stat_o.no_child     = ({slot_q, 1'b0} > (SLOT_BITS+1)'(DEPTH));
    stat_o.has_right    = ({slot_q, 1'b1} <= (SLOT_BITS+1)'(DEPTH));
    stat_o.right_bigger = ck_q < k_rd_q;
    stat_o.dn_go        = nk_q < ck_q;
  end

  assign entry_key_o = ek_q;
  assign top_entry_o = te_q;
  assign top_key_o   = tk_q;
endmodule
`default_nettype wire

>>> rtl/ihpu_ctrl.sv
// Controller: sequences clearing, sift up, sift down and result collection.
`default_nettype none
module ihpu_ctrl import ihpu_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    cmd_o = '0; state_d = state_q;
    in_ready_o = 1'b0; out_valid_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        if (stat_i.clr_done) state_d = ST_IDLE;
        else cmd_o.clr_step = 1'b1;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin cmd_o.latch_req = 1'b1; state_d = ST_RD_E; end
      end
      ST_RD_E: begin
        cmd_o.rd_req = 1'b1; state_d = ST_RD_OLD;
      end
      ST_RD_OLD: begin
        // Take the slot and old key; pick the sift direction on a set.
        cmd_o.start = 1'b1;
        if (!stat_i.is_set) state_d = ST_TOP1;
        else if (stat_i.rd_lt_new) state_d = ST_UP_P1;
        else state_d = ST_DN_C1;
      end
      ST_UP_P1: begin
        if (stat_i.at_root) state_d = ST_PLACE;
        else begin
          cmd_o.rd_s2e = 1'b1; cmd_o.sel_a = SEL_PARENT; state_d = ST_UP_P2;
        end
      end
      ST_UP_P2: begin
        cmd_o.rd_key_s2e = 1'b1; cmd_o.latch_ce = 1'b1; state_d = ST_UP_P3;
      end
      ST_UP_P3: begin
        // Pull the parent down while its key is smaller.
        if (stat_i.rd_lt_new) begin
          cmd_o.move_up = 1'b1; state_d = ST_UP_P1;
        end else state_d = ST_PLACE;
      end
      ST_DN_C1: begin
        if (stat_i.no_child) state_d = ST_PLACE;
        else begin
          cmd_o.rd_s2e = 1'b1; cmd_o.sel_a = SEL_LEFT; state_d = ST_DN_C2;
        end
      end
      ST_DN_C2: begin
        cmd_o.rd_key_s2e = 1'b1; cmd_o.latch_ce = 1'b1;
        if (stat_i.has_right) begin cmd_o.rd_s2e = 1'b1; cmd_o.sel_a = SEL_RIGHT; end
        state_d = ST_DN_C3;
      end
      ST_DN_C3: begin
        // Hold the left child as candidate; fetch the right key if there is one.
        cmd_o.latch_ck = 1'b1;
        if (stat_i.has_right) begin
          cmd_o.rd_key_s2e = 1'b1; state_d = ST_DN_C4;
        end else state_d = ST_DN_C5;
      end
      ST_DN_C4: begin
        // Take the right child only when strictly larger.
        if (stat_i.right_bigger) cmd_o.pick_right = 1'b1;
        state_d = ST_DN_C5;
      end
      ST_DN_C5: begin
        if (stat_i.dn_go) begin
          cmd_o.move_dn = 1'b1; state_d = ST_DN_C1;
        end else state_d = ST_PLACE;
      end
      ST_PLACE: begin
        cmd_o.place = 1'b1; state_d = ST_TOP1;
      end
      ST_TOP1: begin
        cmd_o.rd_s2e = 1'b1; cmd_o.sel_a = SEL_ROOT; state_d = ST_TOP2;
      end
      ST_TOP2: begin
        cmd_o.rd_key_s2e = 1'b1; cmd_o.latch_te = 1'b1; state_d = ST_TOP3;
      end
      ST_TOP3: begin
        cmd_o.latch_tk = 1'b1; state_d = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end
endmodule
`default_nettype wire

>>> rtl/indexed_heap_priority_update_top.sv
// Top level of the indexed heap priority update block.
// Sequence: a read passes ST_RD_E, ST_RD_OLD and the root lookup ST_TOP1 to ST_TOP3; a set
//   sifts between them, through ST_UP_P1 to ST_UP_P3 per level up or ST_DN_C1 to ST_DN_C5
//   per level down (ST_DN_C4 only with a right child). One request in flight; the next
//   is accepted in the cycle after the result leaves ST_OUT.
// Reset: asynchronous, active low; a clearing pass over all 1024 entries follows with in_ready_o low.
`default_nettype none
module indexed_heap_priority_update_top import ihpu_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire logic op_i,
  input  wire ent_t entry_i,
  input  wire key_t key_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output key_t      entry_key_o,
  output ent_t      top_entry_o,
  output key_t      top_key_o
);
  cmd_t cmd; stat_t stat;
  ihpu_ctrl u_ctrl (.clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o,
    .out_ready_i, .stat_i(stat), .cmd_o(cmd));
  ihpu_datapath u_dp (.clk_i, .rst_ni, .cmd_i(cmd), .op_i, .entry_i, .key_i,
    .stat_o(stat), .entry_key_o, .top_entry_o, .top_key_o);
endmodule
`default_nettype wire

>>> tb/ihpu_checker.sv
// Checker for the indexed heap block: shadow heap, expected results and comparison.
`timescale 1ns / 1ps
module ihpu_checker import ihpu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  logic op_i,
  input  ent_t entry_i,
  input  key_t key_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  key_t entry_key_i,
  input  ent_t top_entry_i,
  input  key_t top_key_i,
  output int   fail_count_o,
  output int   pending_o
);
  typedef struct packed {
    key_t ek;
    ent_t te;
    key_t tk;
  } heap_result_t;

  key_t         shadow_key [DEPTH];
  int unsigned  ent_slot [DEPTH];
  int unsigned  slot_ent [DEPTH+1];
  heap_result_t expected_q [$];

  // Move an entry into a slot and keep both maps in step.
  function automatic void put(int unsigned s, int unsigned e);
    slot_ent[s] = e;
    ent_slot[e] = s;
  endfunction

  function automatic void lift_slot(int unsigned s);
    int unsigned e;
    key_t k;
    e = slot_ent[s];
    k = shadow_key[e];
    while (s > 1 && shadow_key[slot_ent[s>>1]] < k) begin
      put(s, slot_ent[s>>1]);
      s = s >> 1;
    end
    put(s, e);
  endfunction

  function automatic void sink_slot(int unsigned s);
    int unsigned e, c;
    key_t k;
    e = slot_ent[s];
    k = shadow_key[e];
    forever begin
      c = s << 1;
      if (c > DEPTH) break;
      if (c + 1 <= DEPTH && shadow_key[slot_ent[c]] < shadow_key[slot_ent[c+1]]) c++;
      if (!(k < shadow_key[slot_ent[c]])) break;
      put(s, slot_ent[c]);
      s = c;
    end
    put(s, e);
  endfunction

  // Apply one request to the shadow heap and return its result.
  function automatic heap_result_t apply_request(logic op, ent_t e, key_t k);
    heap_result_t r;
    key_t old;
    if (op == OP_SET) begin
      old = shadow_key[e];
      shadow_key[e] = k;
      if (old < k) lift_slot(ent_slot[e]);
      else sink_slot(ent_slot[e]);
    end
    r.ek = shadow_key[e];
    r.te = ent_t'(slot_ent[1]);
    r.tk = shadow_key[slot_ent[1]];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    heap_result_t x;
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        shadow_key[i] = '0;
        ent_slot[i] = i + 1;
        slot_ent[i+1] = i;
      end
      expected_q.delete();
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      // Compare the result first; a request accepted now cannot answer in the same edge.
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result ek=%0h te=%0d tk=%0h", entry_key_i, top_entry_i,
                 top_key_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          x = expected_q.pop_front();
          if (entry_key_i !== x.ek || top_entry_i !== x.te || top_key_i !== x.tk)
            fail_count_o <= fail_count_o + 1;
          if (entry_key_i !== x.ek)
            $error("entry_key expected %0h actual %0h", x.ek, entry_key_i);
          if (top_entry_i !== x.te)
            $error("top_entry expected %0d actual %0d", x.te, top_entry_i);
          if (top_key_i !== x.tk)
            $error("top_key expected %0h actual %0h", x.tk, top_key_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        x = apply_request(op_i, entry_i, key_i);
        expected_q.insert(expected_q.size(), x);
      end
      pending_o <= expected_q.size();
    end
  end
endmodule

>>> tb/indexed_heap_priority_update_top_tb.sv
// Testbench top: clock, reset, request stimulus and verdict for the heap block.
`timescale 1ns / 1ps
module indexed_heap_priority_update_top_tb;
  import ihpu_pkg::*;

  localparam int LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic op_i = OP_READ;
  ent_t entry_i = '0;
  key_t key_i = '0;
  logic out_ready_i = 1'b0;
  logic in_ready_o, out_valid_o;
  key_t entry_key_o, top_key_o;
  ent_t top_entry_o;
  int   fail_count, pending, cycles;
  bit   busy_phase = 1'b1;

  always #5 clk_i = ~clk_i;

  indexed_heap_priority_update_top dut (.*);

  ihpu_checker u_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .op_i, .entry_i, .key_i,
    .out_valid_i(out_valid_o), .out_ready_i, .entry_key_i(entry_key_o),
    .top_entry_i(top_entry_o), .top_key_i(top_key_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Stall the result side at random, except in the busy phase.
  always @(posedge clk_i) begin
    out_ready_i <= busy_phase ? 1'b1 : ($urandom_range(99) >= 28);
  end

  // Guard against a hung block.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Present one request and hold it until accepted; drop valid only while idling.
  task automatic send(logic op, ent_t e, key_t k);
    if (!busy_phase)
      while ($urandom_range(99) < 28) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    in_valid_i <= 1'b1;
    op_i <= op;
    entry_i <= e;
    key_i <= k;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Pick keys that often collide so ties and equal updates happen.
  function automatic key_t pick_key();
    case ($urandom_range(4))
      0: return '0;
      1: return '1;
      2: return key_t'($urandom_range(15));
      default: return key_t'($urandom);
    endcase
  endfunction

  initial begin
    int wait_n;
    cycles = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: reads of reset state, extremes, equal keys, decreases.
    send(OP_READ, '0, '1);
    send(OP_READ, ent_t'(DEPTH - 1), '0);
    send(OP_SET, ent_t'(DEPTH - 1), '1);
    send(OP_SET, '0, '1);
    send(OP_SET, '0, '1);
    send(OP_SET, ent_t'(DEPTH - 1), '0);
    send(OP_SET, 10'd512, 32'h8000_0000);
    send(OP_SET, 10'd513, 32'h8000_0000);
    send(OP_SET, '0, 32'h0000_0001);
    send(OP_SET, 10'd341, 32'h5555_5555);
    send(OP_SET, 10'd682, 32'hAAAA_AAAA);
    send(OP_SET, 10'd682, '0);
    send(OP_READ, 10'd682, 32'h1234_5678);
    send(OP_SET, 10'd1, '0);
    send(OP_SET, 10'd2, 32'd7);
    send(OP_SET, 10'd2, 32'd3);
    send(OP_READ, '0, '0);
    // Random: first a stretch with no idling, then random idling.
    for (int i = 0; i < 1150; i++) begin
      if (i == 150) busy_phase = 1'b0;
      if ($urandom_range(3) == 0)
        send(OP_READ, ent_t'($urandom), key_t'($urandom));
      else if ($urandom_range(3) == 0)
        send(OP_SET, ent_t'($urandom_range(15)), pick_key());
      else
        send(OP_SET, ent_t'($urandom), pick_key());
    end
    in_valid_i <= 1'b0;
    wait_n = 0;
    while (pending != 0 && wait_n < 20000) begin
      @(posedge clk_i);
      wait_n++;
    end
    repeat (100) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

>>> filelist.f
rtl/ihpu_pkg.sv
rtl/ihpu_datapath.sv
rtl/ihpu_ctrl.sv
rtl/indexed_heap_priority_update_top.sv
tb/ihpu_checker.sv
tb/indexed_heap_priority_update_top_tb.sv
